>>> rtl/bbq_pkg.sv
`timescale 1ns / 1ps

package bbq_pkg;

	// field widths
	localparam int CHAN_W   = 4;
	localparam int SAMPLE_W = 32;
	localparam int COEF_W   = 29;
	localparam int GAIN_W   = 28;
	localparam int CFG_W    = 29;
	localparam int CFG_IDX_W = 2;

	// q27 arithmetic
	localparam int TAPS_W   = SAMPLE_W + 2;
	localparam int GPROD_W  = GAIN_W + 1 + TAPS_W;
	localparam int FPROD_W  = COEF_W + SAMPLE_W;
	localparam int ACC_W    = 64;
	localparam int Q_SHIFT  = 27;
	localparam int SHIFTED_W = ACC_W - Q_SHIFT;
	localparam logic signed [ACC_W-1:0] ROUND_HALF = 64'sd67108864;

	// register reset values
	localparam logic signed [COEF_W-1:0] COEF1_RESET = -29'sd209516300;
	localparam logic signed [COEF_W-1:0] COEF2_RESET = 29'sd86080746;
	localparam logic [GAIN_W-1:0]        GAIN_RESET  = 28'd2695544;

	// default channel count
	localparam int CHANNELS_DEFAULT = 16;

	// configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_FEEDBACK_COEF_1 = 2'd0,
		REG_FEEDBACK_COEF_2 = 2'd1,
		REG_GAIN            = 2'd2
	} cfg_reg_t;

endpackage

>>> rtl/bbq_datapath.sv
`timescale 1ns / 1ps

module bbq_datapath (
	input  logic signed [bbq_pkg::SAMPLE_W-1:0] sample,
	input  logic signed [bbq_pkg::SAMPLE_W-1:0] x1,
	input  logic signed [bbq_pkg::SAMPLE_W-1:0] x2,
	input  logic signed [bbq_pkg::SAMPLE_W-1:0] y1,
	input  logic signed [bbq_pkg::SAMPLE_W-1:0] y2,
	input  logic signed [bbq_pkg::COEF_W-1:0]   coef1,
	input  logic signed [bbq_pkg::COEF_W-1:0]   coef2,
	input  logic        [bbq_pkg::GAIN_W-1:0]   gain,
	output logic signed [bbq_pkg::SAMPLE_W-1:0] y
);
	import bbq_pkg::*;

	logic signed [TAPS_W-1:0]    taps;
	logic signed [GAIN_W:0]      gain_s;
	logic signed [GPROD_W-1:0]   gprod;
	logic signed [FPROD_W-1:0]   fprod1;
	logic signed [FPROD_W-1:0]   fprod2;
	logic signed [ACC_W-1:0]     acc;
	logic signed [SHIFTED_W-1:0] shifted;
	logic                        fits;

	// 1-2-1 weighted input sum at full width
	assign taps = TAPS_W'(sample) + (TAPS_W'(x1) <<< 1) + TAPS_W'(x2);

	// three independent products
	assign gain_s = $signed({1'b0, gain});
	assign gprod  = GPROD_W'(gain_s) * GPROD_W'(taps);
	assign fprod1 = FPROD_W'(coef1) * FPROD_W'(y1);
	assign fprod2 = FPROD_W'(coef2) * FPROD_W'(y2);

	// accumulate with rounding offset, then floor shift
	assign acc = ACC_W'(gprod) - ACC_W'(fprod1) - ACC_W'(fprod2) + ROUND_HALF;
	assign shifted = acc[ACC_W-1:Q_SHIFT];

	// saturate to 32 bits
	assign fits = (shifted[SHIFTED_W-1:SAMPLE_W-1] == '0)
		|| (shifted[SHIFTED_W-1:SAMPLE_W-1] == '1);

	always_comb begin
		priority if (fits) begin
			y = shifted[SAMPLE_W-1:0];
		end else if (shifted[SHIFTED_W-1]) begin
			y = {1'b1, {(SAMPLE_W-1){1'b0}}};
		end else begin
			y = {1'b0, {(SAMPLE_W-1){1'b1}}};
		end
	end

endmodule

>>> rtl/butterworth_biquad_q27_multichannel.sv
`timescale 1ns / 1ps

// Per-channel second-order Butterworth low-pass in Q27 fixed point. Each input
// transaction names a channel and brings a signed 32-bit sample; one output
// transaction follows with the rounded, saturated filter output
// round((g*(x0+2*x1+x2) - b1*y1 - b2*y2) / 2^27) for that channel. The block
// takes one transaction per cycle unless a stalled result blocks it. Each
// passes an input register, then three multipliers and a 64-bit sum feeding
// the output register, which also updates the channel history in the same
// cycle, so consecutive samples of one channel see each other's results. The
// history of all channels is cleared by reset. A channel at or above CHANNELS
// gives a zero result and leaves all history alone. Coefficients are written
// on the cfg port (index 0: feedback_coef_1, 1: feedback_coef_2, 2: gain);
// the user must do this only while no transaction is in flight (not enforced).
module butterworth_biquad_q27_multichannel #(
	parameter int CHANNELS = bbq_pkg::CHANNELS_DEFAULT
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_write,
	input  logic [bbq_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [bbq_pkg::CFG_W-1:0]           cfg_data,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [bbq_pkg::CHAN_W-1:0]          channel,
	input  logic signed [bbq_pkg::SAMPLE_W-1:0] sample,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [bbq_pkg::CHAN_W-1:0]          out_channel,
	output logic signed [bbq_pkg::SAMPLE_W-1:0] filtered
);
	import bbq_pkg::*;

	localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

	logic signed [COEF_W-1:0]   coef1_q;
	logic signed [COEF_W-1:0]   coef2_q;
	logic        [GAIN_W-1:0]   gain_q;

	logic                       valid_s1;
	logic [CHAN_W-1:0]          channel_s1;
	logic signed [SAMPLE_W-1:0] sample_s1;

	logic signed [SAMPLE_W-1:0] x1_q [CHANNELS];
	logic signed [SAMPLE_W-1:0] x2_q [CHANNELS];
	logic signed [SAMPLE_W-1:0] y1_q [CHANNELS];
	logic signed [SAMPLE_W-1:0] y2_q [CHANNELS];

	logic [IDX_W+CHAN_W-1:0]    chan_ext;
	logic [IDX_W-1:0]           idx;
	logic                       in_range;
	logic                       advance;
	logic signed [SAMPLE_W-1:0] hx1, hx2, hy1, hy2;
	logic signed [SAMPLE_W-1:0] y_new;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef1_q <= COEF1_RESET;
			coef2_q <= COEF2_RESET;
			gain_q  <= GAIN_RESET;
		end else if (cfg_write) begin
			unique case (cfg_index)
				REG_FEEDBACK_COEF_1: coef1_q <= $signed(cfg_data[COEF_W-1:0]);
				REG_FEEDBACK_COEF_2: coef2_q <= $signed(cfg_data[COEF_W-1:0]);
				REG_GAIN:            gain_q  <= cfg_data[GAIN_W-1:0];
				default: ;
			endcase
		end
	end

	// handshake: stage 1 moves on when the output register is free or drains
	assign advance  = valid_s1 && (!out_valid || out_ready);
	assign in_ready = !valid_s1 || advance;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			channel_s1 <= channel;
			sample_s1  <= sample;
		end
	end

	// history lookup for the channel in stage 1
	assign chan_ext = (IDX_W + CHAN_W)'(channel_s1);
	assign idx      = chan_ext[IDX_W-1:0];
	assign in_range = 32'(channel_s1) < CHANNELS;

	always_comb begin
		hx1 = x1_q[idx];
		hx2 = x2_q[idx];
		hy1 = y1_q[idx];
		hy2 = y2_q[idx];
	end

	bbq_datapath u_datapath (
		.sample (sample_s1),
		.x1     (hx1),
		.x2     (hx2),
		.y1     (hy1),
		.y2     (hy2),
		.coef1  (coef1_q),
		.coef2  (coef2_q),
		.gain   (gain_q),
		.y      (y_new)
	);

	// channel history, shifted when a transaction completes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CHANNELS; i++) begin
				x1_q[i] <= '0;
				x2_q[i] <= '0;
				y1_q[i] <= '0;
				y2_q[i] <= '0;
			end
		end else if (advance && in_range) begin
			x1_q[idx] <= sample_s1;
			x2_q[idx] <= hx1;
			y1_q[idx] <= y_new;
			y2_q[idx] <= hy1;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (!out_valid || out_ready) begin
			out_valid <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_channel <= channel_s1;
			filtered    <= in_range ? y_new : '0;
		end
	end

endmodule

>>> rtl/bbq_checker.sv
`timescale 1ns / 1ps

module bbq_checker #(
	parameter int CHANNELS = bbq_pkg::CHANNELS_DEFAULT
) (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                in_valid,
	input logic                                in_ready,
	input logic                                out_valid,
	input logic                                out_ready,
	input logic [bbq_pkg::CHAN_W-1:0]          out_channel,
	input logic signed [bbq_pkg::SAMPLE_W-1:0] filtered
);

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(filtered)
			&& $stable(out_channel))
		else $error("output transaction changed while stalled");

	// input side only stalls behind a waiting result
	a_ready_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid && !out_ready)
		else $error("input stalled with no waiting output");

	// an accepted transaction leads, via the input register, to a valid output register
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |-> ##2 out_valid)
		else $error("accepted transaction did not reach the output");

	// channels without history give zero
	a_out_of_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (32'(out_channel) >= CHANNELS) |-> filtered == '0)
		else $error("nonzero result on channel without history");

endmodule

bind butterworth_biquad_q27_multichannel bbq_checker #(.CHANNELS(CHANNELS)) u_bbq_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (in_valid),
	.in_ready    (in_ready),
	.out_valid   (out_valid),
	.out_ready   (out_ready),
	.out_channel (out_channel),
	.filtered    (filtered)
);

>>> dv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
	import bbq_pkg::*;

	localparam int NUM_CH          = CHANNELS_DEFAULT;
	localparam int N_DIRECTED      = 25;
	localparam int PHASES          = 3;
	localparam int BLOCKS_PER_PHASE = 6;
	localparam int ITEMS_PER_BLOCK = 111;
	localparam int QUIET_LIMIT     = 1000;
	localparam int DRAIN_CYCLES    = 8;

	localparam logic [CFG_IDX_W-1:0] REG_NONE = 2'd3;

	localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 32'sh7fffffff;
	localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 32'sh80000000;
	localparam longint SAT_MAX = 64'sd2147483647;
	localparam longint SAT_MIN = -64'sd2147483648;
	localparam int COEF_MAX = 268435455;
	localparam int COEF_MIN = -268435456;
	localparam int GAIN_MAX = 268435455;
	localparam int UNITY    = 134217728;

	typedef enum logic {ROW_WRITE, ROW_SAMPLE} row_kind_t;
	typedef enum logic [1:0] {CFG_DEFAULT, CFG_STABLE, CFG_RAW, CFG_EXTREME} cfg_mode_t;

	typedef struct packed {
		row_kind_t                    kind;
		logic [CFG_IDX_W-1:0]         idx;
		logic [CHAN_W-1:0]            chan;
		logic signed [SAMPLE_W-1:0]   value;
		logic                         has_lit;
		logic signed [SAMPLE_W-1:0]   lit;
	} stim_row_t;

	typedef struct packed {
		logic [CHAN_W-1:0]            chan;
		logic signed [SAMPLE_W-1:0]   value;
	} filtered_out_t;

	logic                          clk = 1'b0;
	logic                          arst_n = 1'b0;
	logic                          cfg_write = 1'b0;
	logic [CFG_IDX_W-1:0]          cfg_index = '0;
	logic [CFG_W-1:0]              cfg_data = '0;
	logic                          in_valid = 1'b0;
	logic                          in_ready;
	logic [CHAN_W-1:0]             channel = '0;
	logic signed [SAMPLE_W-1:0]    sample = '0;
	logic                          out_valid;
	logic                          out_ready = 1'b0;
	logic [CHAN_W-1:0]             out_channel;
	logic signed [SAMPLE_W-1:0]    filtered;

	// filter coefficients and per-channel history as the block should hold them
	logic signed [COEF_W-1:0]      coef1_q = COEF1_RESET;
	logic signed [COEF_W-1:0]      coef2_q = COEF2_RESET;
	logic [GAIN_W-1:0]             gain_q  = GAIN_RESET;
	logic signed [SAMPLE_W-1:0]    x_last [NUM_CH];
	logic signed [SAMPLE_W-1:0]    x_prev [NUM_CH];
	logic signed [SAMPLE_W-1:0]    y_last [NUM_CH];
	logic signed [SAMPLE_W-1:0]    y_prev [NUM_CH];

	filtered_out_t expected_out [$];
	filtered_out_t oldest;
	int            errors = 0;
	int            quiet_cycles = 0;
	int            send_idle_pct = 30;
	int            recv_stall_pct = 51;

	// directed rows: literal expectations only where they are obvious
	stim_row_t directed_rows [N_DIRECTED] = '{
		'{ROW_SAMPLE, REG_NONE, 4'd0, 32'sd0, 1'b1, 32'sd0},
		'{ROW_SAMPLE, REG_NONE, 4'd1, SAMPLE_MAX, 1'b0, 32'sd0},
		'{ROW_SAMPLE, REG_NONE, 4'd1, SAMPLE_MIN, 1'b0, 32'sd0},
		'{ROW_WRITE, REG_FEEDBACK_COEF_1, 4'd0, 32'sd0, 1'b0, 32'sd0},
		'{ROW_WRITE, REG_FEEDBACK_COEF_2, 4'd0, 32'sd0, 1'b0, 32'sd0},
		'{ROW_WRITE, REG_GAIN, 4'd0, UNITY, 1'b0, 32'sd0},
		'{ROW_SAMPLE, REG_NONE, 4'd2, 32'sd1000, 1'b1, 32'sd1000},
		'{ROW_SAMPLE, REG_NONE, 4'd2, 32'sd0, 1'b1, 32'sd2000},
		'{ROW_SAMPLE, REG_NONE, 4'd2, 32'sd0, 1'b1, 32'sd1000},
		'{ROW_SAMPLE, REG_NONE, 4'd3, SAMPLE_MAX, 1'b1, SAMPLE_MAX},
		'{ROW_SAMPLE, REG_NONE, 4'd3, SAMPLE_MAX, 1'b1, SAMPLE_MAX},
		'{ROW_SAMPLE, REG_NONE, 4'd4, SAMPLE_MIN, 1'b1, SAMPLE_MIN},
		'{ROW_SAMPLE, REG_NONE, 4'd4, SAMPLE_MIN, 1'b1, SAMPLE_MIN},
		'{ROW_WRITE, REG_NONE, 4'd0, 32'sd0, 1'b0, 32'sd0},
		'{ROW_SAMPLE, REG_NONE, 4'd5, 32'sd5, 1'b1, 32'sd5},
		'{ROW_WRITE, REG_GAIN, 4'd0, 32'sd1, 1'b0, 32'sd0},
		'{ROW_SAMPLE, REG_NONE, 4'd6, 32'sd67108864, 1'b1, 32'sd1},
		'{ROW_SAMPLE, REG_NONE, 4'd7, -32'sd67108864, 1'b1, 32'sd0},
		'{ROW_SAMPLE, REG_NONE, 4'd8, -32'sd67108865, 1'b1, -32'sd1},
		'{ROW_WRITE, REG_FEEDBACK_COEF_1, 4'd0, COEF_MIN, 1'b0, 32'sd0},
		'{ROW_WRITE, REG_FEEDBACK_COEF_2, 4'd0, COEF_MAX, 1'b0, 32'sd0},
		'{ROW_WRITE, REG_GAIN, 4'd0, GAIN_MAX, 1'b0, 32'sd0},
		'{ROW_SAMPLE, REG_NONE, 4'd15, SAMPLE_MAX, 1'b0, 32'sd0},
		'{ROW_SAMPLE, REG_NONE, 4'd15, SAMPLE_MIN, 1'b0, 32'sd0},
		'{ROW_SAMPLE, REG_NONE, 4'd15, 32'sd12345, 1'b0, 32'sd0}
	};

	butterworth_biquad_q27_multichannel dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_write   (cfg_write),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.channel     (channel),
		.sample      (sample),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.out_channel (out_channel),
		.filtered    (filtered)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	// history starts cleared like the block after reset
	initial begin
		for (int k = 0; k < NUM_CH; k++) begin
			x_last[k] = '0;
			x_prev[k] = '0;
			y_last[k] = '0;
			y_prev[k] = '0;
		end
	end

	// one biquad step on a channel, advancing its history
	function automatic logic signed [SAMPLE_W-1:0] biquad_step(logic [CHAN_W-1:0] ch,
			logic signed [SAMPLE_W-1:0] x0);
		longint taps;
		longint acc;
		longint y;
		logic signed [SAMPLE_W-1:0] y_sat;
		if (ch >= NUM_CH)
			return '0;
		taps = longint'(x0) + 2 * longint'(x_last[ch]) + longint'(x_prev[ch]);
		acc = longint'(gain_q) * taps
			- (longint'(coef1_q) * longint'(y_last[ch]) + longint'(coef2_q) * longint'(y_prev[ch]));
		y = (acc + ROUND_HALF) >>> Q_SHIFT;
		if (y > SAT_MAX)
			y_sat = SAMPLE_MAX;
		else if (y < SAT_MIN)
			y_sat = SAMPLE_MIN;
		else
			y_sat = y[SAMPLE_W-1:0];
		x_prev[ch] = x_last[ch];
		x_last[ch] = x0;
		y_prev[ch] = y_last[ch];
		y_last[ch] = y_sat;
		return y_sat;
	endfunction

	// register write, issued only once every output has drained
	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
		in_valid <= 1'b0;
		while (expected_out.size() != 0)
			@(posedge clk);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		case (idx)
			REG_FEEDBACK_COEF_1: coef1_q = data[COEF_W-1:0];
			REG_FEEDBACK_COEF_2: coef2_q = data[COEF_W-1:0];
			REG_GAIN:            gain_q = data[GAIN_W-1:0];
			default: ;
		endcase
		cfg_write <= 1'b0;
		@(posedge clk);
	endtask

	// input transaction with optional idle gap in front
	task automatic send_sample(logic [CHAN_W-1:0] ch, logic signed [SAMPLE_W-1:0] s,
			logic has_lit, logic signed [SAMPLE_W-1:0] lit);
		logic signed [SAMPLE_W-1:0] predicted;
		if ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		in_valid <= 1'b1;
		channel <= ch;
		sample <= s;
		do
			@(posedge clk);
		while (!in_ready);
		predicted = biquad_step(ch, s);
		expected_out.push_back('{ch, has_lit ? lit : predicted});
	endtask

	// coefficient sets: reset values, stable random, raw writes, corners
	task automatic load_coefficients(cfg_mode_t mode);
		int b1;
		int b2;
		int lim;
		int g;
		if (mode == CFG_RAW) begin
			for (int k = 0; k < 3; k++)
				write_reg(CFG_IDX_W'($urandom_range(0, 3)), CFG_W'($urandom));
		end else begin
			case (mode)
				CFG_DEFAULT: begin
					b1 = COEF1_RESET;
					b2 = COEF2_RESET;
					g = GAIN_RESET;
				end
				CFG_STABLE: begin
					// poles inside the unit circle: |b2| < 1, |b1| < 1 + b2
					b2 = $urandom_range(0, 2 * UNITY - 2) - (UNITY - 1);
					lim = UNITY + b2 - 1;
					b1 = $urandom_range(0, 2 * lim) - lim;
					g = $urandom_range(0, (1 << $urandom_range(1, GAIN_W)) - 1);
				end
				default: begin
					b1 = $urandom_range(1) ? COEF_MIN : COEF_MAX;
					b2 = $urandom_range(1) ? COEF_MIN : COEF_MAX;
					g = $urandom_range(1) ? 0 : GAIN_MAX;
				end
			endcase
			write_reg(REG_FEEDBACK_COEF_1, b1[CFG_W-1:0]);
			write_reg(REG_FEEDBACK_COEF_2, b2[CFG_W-1:0]);
			write_reg(REG_GAIN, g[CFG_W-1:0]);
		end
	endtask

	// output side stalls
	always @(posedge clk)
		out_ready <= ($urandom_range(99) >= recv_stall_pct);

	// compare each output transaction with the oldest prediction
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (expected_out.size() == 0) begin
				$display("%0t unexpected output: expected none, actual channel %0d filtered %0d",
					$time, out_channel, filtered);
				errors++;
			end else begin
				oldest = expected_out.pop_front();
				if (out_channel !== oldest.chan) begin
					$display("%0t out_channel: expected %0d actual %0d",
						$time, oldest.chan, out_channel);
					errors++;
				end
				if (filtered !== oldest.value) begin
					$display("%0t filtered (channel %0d): expected %0d actual %0d",
						$time, oldest.chan, oldest.value, filtered);
					errors++;
				end
			end
		end
	end

	// watchdog on cycles without any transaction
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("end of test: mismatches");
			$finish;
		end
	end

	// stimulus
	initial begin
		logic [CHAN_W-1:0] ch;
		logic signed [SAMPLE_W-1:0] s;
		ch = '0;
		s = '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < N_DIRECTED; i++) begin
			if (directed_rows[i].kind == ROW_WRITE)
				write_reg(directed_rows[i].idx, directed_rows[i].value[CFG_W-1:0]);
			else
				send_sample(directed_rows[i].chan, directed_rows[i].value,
					directed_rows[i].has_lit, directed_rows[i].lit);
		end

		for (int phase = 0; phase < PHASES; phase++) begin
			send_idle_pct = (phase == 0) ? 30 : (phase == 1) ? 51 : 0;
			recv_stall_pct = (phase == 0) ? 51 : (phase == 1) ? 30 : 0;
			for (int blk = 0; blk < BLOCKS_PER_PHASE; blk++) begin
				load_coefficients(blk == 0 ? CFG_DEFAULT : cfg_mode_t'($urandom_range(0, 3)));
				for (int n = 0; n < ITEMS_PER_BLOCK; n++) begin
					// half the time stay on the channel just used
					if ($urandom_range(1))
						ch = CHAN_W'($urandom_range(0, NUM_CH - 1));
					case ($urandom_range(3))
						0: s = $urandom;
						1: s = $signed($urandom_range(0, 131071)) - 65536;
						2: begin
							case ($urandom_range(3))
								0: s = SAMPLE_MAX;
								1: s = SAMPLE_MIN;
								2: s = '0;
								default: s = -32'sd1;
							endcase
						end
						default: s = $signed($urandom) >>> $urandom_range(1, 20);
					endcase
					send_sample(ch, s, 1'b0, '0);
				end
			end
		end

		// drain
		in_valid <= 1'b0;
		while (expected_out.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
